[design/ptrrio_pkg.sv]
// Shared codes and field widths of the per-target round-robin I/O scheduler.
`timescale 1ns / 1ps

package ptrrio_pkg;

    localparam int CMD_W    = 2;
    localparam int TGT_W    = 3;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_SUBMIT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_ACTIVE = 2'd3;

endpackage

[design/ptrrio_tag_ram.sv]
// Tag store: one circular queue region per target, one write and one read port.
`timescale 1ns / 1ps

module ptrrio_tag_ram #(
    parameter int ADDR_W = 7
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [ptrrio_pkg::TAG_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [ptrrio_pkg::TAG_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [ptrrio_pkg::TAG_W-1:0] mem [DEPTH];
    logic [ptrrio_pkg::TAG_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/ptrrio_meta_ram.sv]
// Per-target queue head index and fill count; entries read as zero until written.
`timescale 1ns / 1ps

module ptrrio_meta_ram #(
    parameter int DEPTH   = 8,
    parameter int ADDR_W  = 3,
    parameter int FRONT_W = 4,
    parameter int COUNT_W = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [FRONT_W-1:0] wr_front,
    input  logic [COUNT_W-1:0] wr_count,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [FRONT_W-1:0] rd_front,
    output logic [COUNT_W-1:0] rd_count
);

    logic [FRONT_W-1:0] front_mem [DEPTH];
    logic [COUNT_W-1:0] count_mem [DEPTH];
    logic [DEPTH-1:0]   written_reg;
    logic [FRONT_W-1:0] rd_front_reg;
    logic [COUNT_W-1:0] rd_count_reg;
    logic               rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            front_mem[wr_addr] <= wr_front;
            count_mem[wr_addr] <= wr_count;
        end
        if (rd_en) begin
            rd_front_reg <= front_mem[rd_addr];
            rd_count_reg <= count_mem[rd_addr];
        end
    end

    // Track written entries so the store needs no clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_front = rd_hit_reg ? rd_front_reg : '0;
    assign rd_count = rd_hit_reg ? rd_count_reg : '0;

endmodule

[design/ptrrio_rr_pick.sv]
// Round-robin pick of the first available target at or after the start point.
`timescale 1ns / 1ps

module ptrrio_rr_pick #(
    parameter int NUM_TARGETS = 8,
    parameter int TGT_IDX_W   = 3
) (
    input  logic [NUM_TARGETS-1:0] avail,
    input  logic [TGT_IDX_W-1:0]   start,
    output logic                   found,
    output logic [TGT_IDX_W-1:0]   win
);

    logic [2*NUM_TARGETS-1:0] dbl;
    logic [NUM_TARGETS-1:0]   rot;
    logic [TGT_IDX_W-1:0]     offset;
    logic [TGT_IDX_W:0]       sum;

    always_comb begin
        dbl    = {avail, avail} >> start;
        rot    = dbl[NUM_TARGETS-1:0];
        offset = '0;
        for (int i = NUM_TARGETS - 1; i >= 0; i--) begin
            if (rot[i]) begin
                offset = TGT_IDX_W'(i);
            end
        end
        sum = {1'b0, start} + {1'b0, offset};
        if (sum >= (TGT_IDX_W + 1)'(NUM_TARGETS)) begin
            sum = sum - (TGT_IDX_W + 1)'(NUM_TARGETS);
        end
    end

    assign found = |avail;
    assign win   = sum[TGT_IDX_W-1:0];

endmodule

[design/per_target_round_robin_io_scheduler.sv]
// Top level: per-target request queues with a round-robin start scheduler.
// Path: a rejected word goes straight to the result load; an accepted one has its meta RAM
// read, then the update, then the result load when the bus is busy; otherwise a scan follows,
// then the result load when it finds nothing, or, when one starts, a pop with tag read and the result load.
// A new word is taken only after the last result is loaded; there is no overlap of words.
// Reset (aresetn low, synchronous) empties all queues, clears busy marks, scan point to 0.
`timescale 1ns / 1ps

module per_target_round_robin_io_scheduler #(
    parameter int NUM_TARGETS = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // target[2:0], tag[10:3], at_head[11], bus_free[12]
    input  logic [1:0]  s_tuser,  // cmd[1:0]
    // Result word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // start_valid[0], start_target[3:1], start_tag[11:4],
                                  // status[13:12]
);

    localparam int TW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int AW = TW + QW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_POP,
        ST_RESULT
    } state_t;

    // Input word fields
    logic [ptrrio_pkg::CMD_W-1:0] in_cmd;
    logic [ptrrio_pkg::TGT_W-1:0] in_target;
    logic [ptrrio_pkg::TAG_W-1:0] in_tag;
    logic                         in_at_head;
    logic                         in_bus_free;

    assign in_cmd      = s_tuser[1:0];
    assign in_target   = s_tdata[2:0];
    assign in_tag      = s_tdata[10:3];
    assign in_at_head  = s_tdata[11];
    assign in_bus_free = s_tdata[12];

    // Registers
    state_t                          state_reg, state_next;
    logic [ptrrio_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [TW-1:0]                   tgt_reg, tgt_next;
    logic [ptrrio_pkg::TAG_W-1:0]    tag_reg, tag_next;
    logic                            at_head_reg, at_head_next;
    logic                            bus_free_reg, bus_free_next;
    logic [ptrrio_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                            started_reg, started_next;
    logic [TW-1:0]                   win_reg, win_next;
    logic [TW-1:0]                   scan_start_reg, scan_start_next;
    logic [NUM_TARGETS-1:0]          busy_reg, busy_next;
    logic [NUM_TARGETS-1:0]          nonempty_reg, nonempty_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [15:0]                     m_tdata_reg, m_tdata_next;

    // Memory ports
    logic                         meta_wr_en, meta_rd_en;
    logic [TW-1:0]                meta_wr_addr, meta_rd_addr;
    logic [QW-1:0]                meta_wr_front, meta_rd_front;
    logic [CW-1:0]                meta_wr_count, meta_rd_count;
    logic                         tag_wr_en, tag_rd_en;
    logic [AW-1:0]                tag_wr_addr, tag_rd_addr;
    logic [ptrrio_pkg::TAG_W-1:0] tag_rd_data;

    // Scan
    logic          pick_found;
    logic [TW-1:0] pick_win;

    // Queue index arithmetic
    logic          q_full;
    logic [QW-1:0] front_inc, front_dec, pos_back;
    logic [SW-1:0] back_sum;
    logic          in_reject;

    ptrrio_meta_ram #(
        .DEPTH   (NUM_TARGETS),
        .ADDR_W  (TW),
        .FRONT_W (QW),
        .COUNT_W (CW)
    ) u_meta_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (meta_wr_en),
        .wr_addr  (meta_wr_addr),
        .wr_front (meta_wr_front),
        .wr_count (meta_wr_count),
        .rd_en    (meta_rd_en),
        .rd_addr  (meta_rd_addr),
        .rd_front (meta_rd_front),
        .rd_count (meta_rd_count)
    );

    ptrrio_tag_ram #(
        .ADDR_W (AW)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_wr_en),
        .wr_addr (tag_wr_addr),
        .wr_data (tag_reg),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rd_data)
    );

    ptrrio_rr_pick #(
        .NUM_TARGETS (NUM_TARGETS),
        .TGT_IDX_W   (TW)
    ) u_rr_pick (
        .avail (~busy_reg & nonempty_reg),
        .start (scan_start_reg),
        .found (pick_found),
        .win   (pick_win)
    );

    // Reject unknown commands and targets beyond the configured count.
    assign in_reject = (in_cmd != ptrrio_pkg::CMD_SUBMIT && in_cmd != ptrrio_pkg::CMD_COMPLETE)
                    || (32'(in_target) >= NUM_TARGETS);

    // Circular index helpers on the meta word read back for the current target.
    always_comb begin
        q_full    = (meta_rd_count == CW'(QUEUE_DEPTH));
        front_inc = (meta_rd_front == QW'(QUEUE_DEPTH - 1)) ? '0 : meta_rd_front + 1'b1;
        front_dec = (meta_rd_front == '0) ? QW'(QUEUE_DEPTH - 1) : meta_rd_front - 1'b1;
        back_sum  = SW'(meta_rd_front) + SW'(meta_rd_count);
        if (back_sum >= SW'(QUEUE_DEPTH)) begin
            pos_back = QW'(back_sum - SW'(QUEUE_DEPTH));
        end else begin
            pos_back = QW'(back_sum);
        end
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        tgt_next        = tgt_reg;
        tag_next        = tag_reg;
        at_head_next    = at_head_reg;
        bus_free_next   = bus_free_reg;
        status_next     = status_reg;
        started_next    = started_reg;
        win_next        = win_reg;
        scan_start_next = scan_start_reg;
        busy_next       = busy_reg;
        nonempty_next   = nonempty_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        meta_rd_en    = 1'b0;
        meta_rd_addr  = tgt_reg;
        meta_wr_en    = 1'b0;
        meta_wr_addr  = tgt_reg;
        meta_wr_front = meta_rd_front;
        meta_wr_count = meta_rd_count;
        tag_wr_en     = 1'b0;
        tag_wr_addr   = {tgt_reg, pos_back};
        tag_rd_en     = 1'b0;
        tag_rd_addr   = {win_reg, meta_rd_front};

        // Drop the result word once the sink takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next      = in_cmd;
                    tgt_next      = TW'(in_target);
                    tag_next      = in_tag;
                    at_head_next  = in_at_head;
                    bus_free_next = in_bus_free;
                    started_next  = 1'b0;
                    if (in_reject) begin
                        status_next = ptrrio_pkg::STATUS_REJECT;
                        state_next  = ST_RESULT;
                    end else begin
                        status_next  = ptrrio_pkg::STATUS_OK;
                        meta_rd_en   = 1'b1;
                        meta_rd_addr = TW'(in_target);
                        state_next   = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                // Apply the submit or completion to the target read back last cycle.
                if (cmd_reg == ptrrio_pkg::CMD_SUBMIT) begin
                    if (q_full) begin
                        status_next = ptrrio_pkg::STATUS_FULL;
                    end else begin
                        tag_wr_en     = 1'b1;
                        tag_wr_addr   = {tgt_reg, at_head_reg ? front_dec : pos_back};
                        meta_wr_en    = 1'b1;
                        meta_wr_front = at_head_reg ? front_dec : meta_rd_front;
                        meta_wr_count = meta_rd_count + 1'b1;
                        nonempty_next[tgt_reg] = 1'b1;
                    end
                end else begin
                    if (busy_reg[tgt_reg]) begin
                        busy_next[tgt_reg] = 1'b0;
                    end else begin
                        status_next = ptrrio_pkg::STATUS_NO_ACTIVE;
                    end
                end
                state_next = bus_free_reg ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN: begin
                if (pick_found) begin
                    started_next       = 1'b1;
                    win_next           = pick_win;
                    busy_next[pick_win] = 1'b1;
                    scan_start_next    = (32'(pick_win) == NUM_TARGETS - 1) ? '0
                                                                            : pick_win + 1'b1;
                    meta_rd_en         = 1'b1;
                    meta_rd_addr       = pick_win;
                    state_next         = ST_POP;
                end else begin
                    // Advance the start point on a miss, but hold it at target 0.
                    if (scan_start_reg != '0) begin
                        scan_start_next = (32'(scan_start_reg) == NUM_TARGETS - 1) ? '0
                                                                : scan_start_reg + 1'b1;
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_POP: begin
                tag_rd_en     = 1'b1;
                tag_rd_addr   = {win_reg, meta_rd_front};
                meta_wr_en    = 1'b1;
                meta_wr_addr  = win_reg;
                meta_wr_front = front_inc;
                meta_wr_count = meta_rd_count - 1'b1;
                if (meta_rd_count == CW'(1)) begin
                    nonempty_next[win_reg] = 1'b0;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // Load the output register once it is free or being drained.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next      = 1'b1;
                    m_tdata_next       = '0;
                    m_tdata_next[0]    = started_reg;
                    m_tdata_next[3:1]  = started_reg ? ptrrio_pkg::TGT_W'(win_reg) : '0;
                    m_tdata_next[11:4] = started_reg ? tag_rd_data : '0;
                    m_tdata_next[13:12] = status_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_start_reg <= '0;
            busy_reg       <= '0;
            nonempty_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            started_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_start_reg <= scan_start_next;
            busy_reg       <= busy_next;
            nonempty_reg   <= nonempty_next;
            m_tvalid_reg   <= m_tvalid_next;
            started_reg    <= started_next;
        end
        cmd_reg      <= cmd_next;
        tgt_reg      <= tgt_next;
        tag_reg      <= tag_next;
        at_head_reg  <= at_head_next;
        bus_free_reg <= bus_free_next;
        status_reg   <= status_next;
        win_reg      <= win_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The scan start point always names an existing target.
    a_scan_start_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(scan_start_reg) < NUM_TARGETS)
        else $error("scan start point out of range");

    // A popped target must hold at least one queued tag.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |-> (meta_rd_count != '0))
        else $error("pop from an empty queue");

    // The target being popped was marked busy by the scan.
    a_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |-> busy_reg[win_reg])
        else $error("popped target not marked busy");

    // A result without a start carries a zero target and tag.
    a_idle_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[11:1] == '0))
        else $error("start fields set without a start");

endmodule
